// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is active.
`define NSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is active.
`define NSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define NSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nss_pkg.sv =====
// Types and constants of the nearest site search block.
package nss_pkg;

  localparam int COORD_BITS   = 16;
  localparam int DIST_BITS    = 34;
  localparam int IN_IDX_BITS  = 11;
  localparam int OUT_IDX_BITS = 10;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_NEAREST = 2'd2,
    ACT_DISC    = 2'd3
  } action_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  typedef struct packed {
    action_t                        action;
    logic signed [COORD_BITS-1:0]   x;
    logic signed [COORD_BITS-1:0]   y;
    logic [DIST_BITS-1:0]           radius_sq;
    logic [IN_IDX_BITS-1:0]         min_index;
    logic [IN_IDX_BITS-1:0]         ignore_index;
  } in_item_t;

  typedef struct packed {
    logic                           found;
    logic [OUT_IDX_BITS-1:0]        site_index;
    logic [DIST_BITS-1:0]           dist_sq;
    status_t                        status;
  } out_item_t;

endpackage

// ===== hdl/nss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [WIDTH-1:0]                  wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [WIDTH-1:0]                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/nss_dist.sv =====
// Three-stage exact squared distance pipeline with index tag.
module nss_dist #(
  parameter int IDX_W = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic [IDX_W-1:0]                       in_idx,
  input  logic signed [nss_pkg::COORD_BITS-1:0]  site_x,
  input  logic signed [nss_pkg::COORD_BITS-1:0]  site_y,
  input  logic signed [nss_pkg::COORD_BITS-1:0]  query_x,
  input  logic signed [nss_pkg::COORD_BITS-1:0]  query_y,
  output logic                                   out_valid,
  output logic [IDX_W-1:0]                       out_idx,
  output logic [nss_pkg::DIST_BITS-1:0]          out_dist,
  output logic                                   busy
);

  localparam int CB = nss_pkg::COORD_BITS;

  logic signed [CB:0]     diff_x;
  logic signed [CB:0]     diff_y;
  logic signed [CB:0]     mag_x;
  logic signed [CB:0]     mag_y;

  logic                   v1_r;
  logic [IDX_W-1:0]       idx1_r;
  logic [CB-1:0]          ax1_r;
  logic [CB-1:0]          ay1_r;

  logic                   v2_r;
  logic [IDX_W-1:0]       idx2_r;
  logic [2*CB-1:0]        sx2_r;
  logic [2*CB-1:0]        sy2_r;

  logic                   v3_r;
  logic [IDX_W-1:0]       idx3_r;
  logic [nss_pkg::DIST_BITS-1:0] d3_r;

  assign diff_x = {site_x[CB-1], site_x} - {query_x[CB-1], query_x};
  assign diff_y = {site_y[CB-1], site_y} - {query_y[CB-1], query_y};
  assign mag_x  = diff_x[CB] ? -diff_x : diff_x;
  assign mag_y  = diff_y[CB] ? -diff_y : diff_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    idx1_r <= in_idx;
    ax1_r  <= mag_x[CB-1:0];
    ay1_r  <= mag_y[CB-1:0];
    idx2_r <= idx1_r;
    sx2_r  <= ax1_r * ax1_r;
    sy2_r  <= ay1_r * ay1_r;
    idx3_r <= idx2_r;
    d3_r   <= nss_pkg::DIST_BITS'(sx2_r) + nss_pkg::DIST_BITS'(sy2_r);
  end

  assign out_valid = v3_r;
  assign out_idx   = idx3_r;
  assign out_dist  = d3_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

// ===== hdl/nearest_site_search.sv =====
// Top level of the nearest site search block.
// Sites live in one RAM of MAX_SITES entries ({x, y} per entry); a clear or an
// append goes straight to the result state. A query scans the stored sites
// through the single RAM read port, one site per cycle, followed by a drain of
// the read and distance pipeline. A nearest query scans all stored sites, a disc
// query scans from min_index on and stops issuing reads at its first hit. The
// output register lets a new item be taken while the previous result waits.
module nearest_site_search #(
  parameter int MAX_SITES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nss_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nss_pkg::out_item_t  out_data
);

  localparam int IW   = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CW   = $clog2(MAX_SITES + 1);
  localparam int CMPW = (CW > nss_pkg::IN_IDX_BITS) ? CW : nss_pkg::IN_IDX_BITS;
  localparam int CB   = nss_pkg::COORD_BITS;
  localparam int DB   = nss_pkg::DIST_BITS;
  localparam int OB   = nss_pkg::OUT_IDX_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CMPW-1:0]      issue_r;
  logic [CMPW-1:0]      ignore_r;
  logic                 disc_r;
  logic signed [CB-1:0] qx_r;
  logic signed [CB-1:0] qy_r;
  logic [DB-1:0]        radius_r;
  logic                 rv_r;
  logic [IW-1:0]        ridx_r;
  logic                 found_r;
  logic [IW-1:0]        best_idx_r;
  logic [DB-1:0]        best_d_r;
  nss_pkg::out_item_t   res_r;
  logic                 out_valid_r;
  nss_pkg::out_item_t   out_data_r;

  logic                 in_fire;
  logic                 room;
  logic                 issuing;
  logic                 skip;
  logic                 scan_done;
  logic                 take;
  logic                 wr_en;
  logic [2*CB-1:0]      rd_data;
  logic                 dv;
  logic [IW-1:0]        didx;
  logic [DB-1:0]        dval;
  logic                 dbusy;
  logic [IW+OB-1:0]     best_wide;
  nss_pkg::out_item_t   scan_res;
  nss_pkg::out_item_t   fixed_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign room      = (count_r < CW'(MAX_SITES));
  assign wr_en     = in_fire & (in_data.action == nss_pkg::ACT_APPEND) & room;

  assign issuing   = (state_r == S_SCAN) && (issue_r < CMPW'(count_r)) &&
                     !(disc_r && found_r);
  assign skip      = disc_r && (issue_r == ignore_r);
  assign scan_done = (state_r == S_SCAN) && !issuing && !rv_r && !dbusy;
  assign take      = dv && (disc_r ? (!found_r && (dval < radius_r))
                                   : (!found_r || (dval < best_d_r)));

  assign best_wide = {{OB{1'b0}}, best_idx_r};

  always_comb begin
    scan_res            = '0;
    scan_res.found      = found_r;
    scan_res.site_index = found_r ? best_wide[OB-1:0] : '0;
    scan_res.dist_sq    = found_r ? best_d_r : '0;
    scan_res.status     = nss_pkg::ST_DONE;
    fixed_res           = '0;
    fixed_res.status    = ((in_data.action == nss_pkg::ACT_APPEND) && !room) ?
                          nss_pkg::ST_FULL : nss_pkg::ST_DONE;
  end

  nss_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_SITES)
  ) u_site_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data ({in_data.x, in_data.y}),
    .rd_en   (issuing),
    .rd_addr (issue_r[IW-1:0]),
    .rd_data (rd_data)
  );

  nss_dist #(
    .IDX_W (IW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rv_r),
    .in_idx    (ridx_r),
    .site_x    (rd_data[2*CB-1:CB]),
    .site_y    (rd_data[CB-1:0]),
    .query_x   (qx_r),
    .query_y   (qy_r),
    .out_valid (dv),
    .out_idx   (didx),
    .out_dist  (dval),
    .busy      (dbusy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= issuing & ~skip;
      if (out_ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.action)
              nss_pkg::ACT_CLEAR: begin
                count_r <= '0;
                state_r <= S_RESULT;
              end
              nss_pkg::ACT_APPEND: begin
                if (room) begin
                  count_r <= count_r + CW'(1);
                end
                state_r <= S_RESULT;
              end
              nss_pkg::ACT_NEAREST: begin
                found_r <= 1'b0;
                state_r <= S_SCAN;
              end
              nss_pkg::ACT_DISC: begin
                found_r <= 1'b0;
                state_r <= S_SCAN;
              end
              default: begin
                state_r <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (take) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      disc_r   <= (in_data.action == nss_pkg::ACT_DISC);
      qx_r     <= in_data.x;
      qy_r     <= in_data.y;
      radius_r <= in_data.radius_sq;
      ignore_r <= CMPW'(in_data.ignore_index);
      issue_r  <= (in_data.action == nss_pkg::ACT_DISC) ? CMPW'(in_data.min_index) : '0;
      res_r    <= fixed_res;
    end else if (issuing) begin
      issue_r <= issue_r + CMPW'(1);
    end
    if (scan_done) begin
      res_r <= scan_res;
    end
    ridx_r <= issue_r[IW-1:0];
    if (take) begin
      best_idx_r <= didx;
      best_d_r   <= dval;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/nss_checker.sv =====
// Port-level assertion checker for the nearest site search block, with its bind.
`include "assert_macros.svh"

module nss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nss_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nss_pkg::out_item_t out_data
);

  `NSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed or dropped while stalled")
  `NSS_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data), "input item changed or dropped while stalled")
  `NSS_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_data.found, (out_data.site_index == '0) && (out_data.dist_sq == '0), "not-found result carries nonzero index or distance")
  `NSS_ASSERT(a_full_no_hit, clk, rst_n, !(out_valid && out_data.found && (out_data.status == nss_pkg::ST_FULL)), "refused append reported a found site")

endmodule

bind nearest_site_search nss_checker u_nss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the nearest site search block.
`timescale 1ns / 100ps

module testbench;

  localparam int SITE_CAP = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned RAD_MAX = 64'h3_FFFF_FFFF;

  typedef struct packed {
    logic              drain;
    nss_pkg::in_item_t item;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  nss_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  nss_pkg::out_item_t out_data;

  pending_t pending_items[$];
  nss_pkg::out_item_t expected_answers[$];

  logic signed [nss_pkg::COORD_BITS-1:0] shadow_x [SITE_CAP];
  logic signed [nss_pkg::COORD_BITS-1:0] shadow_y [SITE_CAP];
  int unsigned shadow_count = 0;

  logic signed [nss_pkg::COORD_BITS-1:0] plan_x [SITE_CAP];
  logic signed [nss_pkg::COORD_BITS-1:0] plan_y [SITE_CAP];
  int plan_count = 0;
  int plan_items = 0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int tx_wait = 0;
  bit tx_burst = 1'b0;
  int rx_wait = 0;
  bit rx_burst = 1'b0;
  int hold_left = 0;
  int hold_mark = 120;
  int accepted_count = 0;
  int fail_count = 0;
  int cycle_count = 0;

  nearest_site_search #(.MAX_SITES(SITE_CAP)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned sq_dist(
    input logic signed [nss_pkg::COORD_BITS-1:0] ax,
    input logic signed [nss_pkg::COORD_BITS-1:0] ay,
    input logic signed [nss_pkg::COORD_BITS-1:0] bx,
    input logic signed [nss_pkg::COORD_BITS-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic nss_pkg::out_item_t predict_site_search(input nss_pkg::in_item_t it);
    nss_pkg::out_item_t r;
    longint unsigned d;
    int unsigned i;
    r = '0;
    r.status = nss_pkg::ST_DONE;
    case (it.action)
      nss_pkg::ACT_CLEAR: shadow_count = 0;
      nss_pkg::ACT_APPEND: begin
        if (shadow_count < SITE_CAP) begin
          shadow_x[shadow_count] = it.x;
          shadow_y[shadow_count] = it.y;
          shadow_count++;
        end else begin
          r.status = nss_pkg::ST_FULL;
        end
      end
      nss_pkg::ACT_NEAREST: begin
        for (i = 0; i < shadow_count; i++) begin
          d = sq_dist(shadow_x[i], shadow_y[i], it.x, it.y);
          if (!r.found || d < r.dist_sq) begin
            r.found = 1'b1;
            r.site_index = i[nss_pkg::OUT_IDX_BITS-1:0];
            r.dist_sq = d[nss_pkg::DIST_BITS-1:0];
          end
        end
      end
      default: begin
        if (it.radius_sq != '0) begin
          for (i = it.min_index; i < shadow_count; i++) begin
            if (i != it.ignore_index) begin
              d = sq_dist(shadow_x[i], shadow_y[i], it.x, it.y);
              if (d < longint'(it.radius_sq)) begin
                r.found = 1'b1;
                r.site_index = i[nss_pkg::OUT_IDX_BITS-1:0];
                r.dist_sq = d[nss_pkg::DIST_BITS-1:0];
                break;
              end
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_coord(input int style);
    case (style)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 16) - 8;
      default: begin
        case ($urandom_range(0, 6))
          0: return -32768;
          1: return -32767;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return 32766;
          default: return 32767;
        endcase
      end
    endcase
  endfunction

  function automatic longint unsigned rnd_rad();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int rnd_idx();
    return $urandom_range(0, 2047);
  endfunction

  task automatic queue_op(input nss_pkg::action_t act, input int px, input int py,
                          input longint unsigned rad, input int lo, input int skip,
                          input bit drain);
    pending_t p;
    p.drain = drain;
    p.item.action = act;
    p.item.x = px[nss_pkg::COORD_BITS-1:0];
    p.item.y = py[nss_pkg::COORD_BITS-1:0];
    p.item.radius_sq = rad[nss_pkg::DIST_BITS-1:0];
    p.item.min_index = lo[nss_pkg::IN_IDX_BITS-1:0];
    p.item.ignore_index = skip[nss_pkg::IN_IDX_BITS-1:0];
    pending_items.push_back(p);
    plan_items++;
    if (act == nss_pkg::ACT_CLEAR) begin
      plan_count = 0;
    end else if (act == nss_pkg::ACT_APPEND && plan_count < SITE_CAP) begin
      plan_x[plan_count] = p.item.x;
      plan_y[plan_count] = p.item.y;
      plan_count++;
    end
  endtask

  task automatic plan_query(input int style);
    int cx;
    int cy;
    int j;
    int lo;
    int skip;
    longint unsigned rad;
    cx = pick_coord(style);
    cy = pick_coord(style);
    if ($urandom_range(0, 2) == 0) begin
      queue_op(nss_pkg::ACT_NEAREST, cx, cy, rnd_rad(), rnd_idx(), rnd_idx(), 1'b0);
    end else begin
      case ($urandom_range(0, 5))
        0: rad = 0;
        1: rad = rnd_rad();
        2: rad = $urandom_range(1, 300);
        default: begin
          if (plan_count > 0) begin
            j = $urandom_range(0, plan_count - 1);
            rad = sq_dist(plan_x[j], plan_y[j], cx[nss_pkg::COORD_BITS-1:0],
                          cy[nss_pkg::COORD_BITS-1:0]) + $urandom_range(0, 2);
          end else begin
            rad = $urandom_range(1, 50);
          end
        end
      endcase
      lo = ($urandom_range(0, 7) == 0) ? rnd_idx() : $urandom_range(0, plan_count);
      skip = ($urandom_range(0, 5) == 0) ? rnd_idx() : $urandom_range(0, plan_count);
      queue_op(nss_pkg::ACT_DISC, cx, cy, rad, lo, skip, 1'b0);
    end
  endtask

  task automatic plan_episode();
    int style;
    style = $urandom_range(0, 2);
    if (plan_count > 40 || $urandom_range(0, 5) == 0)
      queue_op(nss_pkg::ACT_CLEAR, pick_coord(0), pick_coord(0), rnd_rad(), rnd_idx(),
               rnd_idx(), $urandom_range(0, 15) == 0);
    repeat ($urandom_range(1, 8))
      queue_op(nss_pkg::ACT_APPEND, pick_coord(style), pick_coord(style), rnd_rad(),
               rnd_idx(), rnd_idx(), 1'b0);
    repeat ($urandom_range(1, 6)) plan_query(style);
    if ($urandom_range(0, 7) == 0)
      queue_op(nss_pkg::action_t'($urandom_range(0, 3)), pick_coord(0), pick_coord(0),
               rnd_rad(), rnd_idx(), rnd_idx(), 1'b0);
  endtask

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_items.size() > 0 &&
                   (!pending_items[0].drain || expected_answers.size() == 0)) begin
        in_data <= pending_items[0].item;
        in_valid <= 1'b1;
        void'(pending_items.pop_front());
        tx_wait <= tx_burst ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 30) == 0) tx_burst <= !tx_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 30) == 0) rx_burst = !rx_burst;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    out_ready <= rst_n && rx_wait == 0 && hold_left == 0;
  end

  // hold off the result side so the block backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted_count == hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + 1080;
    end
  end

  always @(posedge clk) begin : monitor
    nss_pkg::out_item_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: found=%0d idx=%0d dist=%0d status=%0d",
                     out_data.found, out_data.site_index, out_data.dist_sq, out_data.status);
        end else begin
          want = expected_answers.pop_front();
          if (out_data.found !== want.found || out_data.site_index !== want.site_index ||
              out_data.dist_sq !== want.dist_sq || out_data.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("mismatch: expected found=%0d idx=%0d dist=%0d status=%0d, ",
                     want.found, want.site_index, want.dist_sq, want.status);
              $display("got found=%0d idx=%0d dist=%0d status=%0d",
                       out_data.found, out_data.site_index, out_data.dist_sq,
                       out_data.status);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_answers.push_back(predict_site_search(in_data));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    queue_op(nss_pkg::ACT_NEAREST, 0, 0, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 5, -5, RAD_MAX, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, -32768, -32768, RAD_MAX, 2047, 2047, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, 32767, 32767, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, 32767, -32768, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, -32768, 32767, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, 0, 0, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, 0, 0, RAD_MAX, 1024, 1024, 1'b0);
    queue_op(nss_pkg::ACT_NEAREST, -32768, -32768, RAD_MAX, 2047, 2047, 1'b0);
    queue_op(nss_pkg::ACT_NEAREST, 32767, 32767, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_NEAREST, 1, 1, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, -32768, -32768, RAD_MAX, 1, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, 0, 0, 2047, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, 1, 0, 2047, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, 2, 0, 2047, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, 2, 4, 4, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, 2, 6, 2047, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, RAD_MAX, 2047, 7, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 1, 0, RAD_MAX, 0, 6, 1'b0);
    queue_op(nss_pkg::ACT_CLEAR, -1, -1, RAD_MAX, 2047, 2047, 1'b1);
    queue_op(nss_pkg::ACT_NEAREST, 0, 0, RAD_MAX, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 0, 0, RAD_MAX, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_APPEND, 12, -7, 0, 0, 0, 1'b0);
    queue_op(nss_pkg::ACT_NEAREST, -32768, 32767, 0, 0, 0, 1'b0);

    while (plan_items < 290) plan_episode();

    queue_op(nss_pkg::ACT_DISC, 0, 0, RAD_MAX, 1023, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 0, 0, RAD_MAX, 1024, 0, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 0, 0, RAD_MAX, 1023, 1023, 1'b0);
    queue_op(nss_pkg::ACT_DISC, 0, 0, RAD_MAX, 0, 0, 1'b0);
    repeat (6) plan_query($urandom_range(0, 2));
    queue_op(nss_pkg::ACT_CLEAR, pick_coord(0), pick_coord(0), rnd_rad(), rnd_idx(),
             rnd_idx(), 1'b0);

    while (plan_items < 580) plan_episode();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && expected_answers.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== nearest_site_search.f =====
+incdir+hdl
hdl/nss_pkg.sv
hdl/nss_ram.sv
hdl/nss_dist.sv
hdl/nearest_site_search.sv
hdl/nss_checker.sv
tb/testbench.sv
